@@ rtl/collatz_residue_polynomial_core_assert.svh @@
// assertion macros for the collatz residue polynomial core
`ifndef COLLATZ_RESIDUE_POLYNOMIAL_CORE_ASSERT_SVH
`define COLLATZ_RESIDUE_POLYNOMIAL_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CRP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CRP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/crp_pkg.sv @@
// shared types, constants and power table for the collatz residue core
`default_nettype none
package crp_pkg;

   localparam int ValueWidth = 36;
   localparam int CountWidth = 5;
   localparam int PowWidth   = 32;
   localparam int CmpWidth   = 52;

   localparam logic [PowWidth-1:0] POW3 [21] = '{
      32'd1, 32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187, 32'd6561,
      32'd19683, 32'd59049, 32'd177147, 32'd531441, 32'd1594323, 32'd4782969,
      32'd14348907, 32'd43046721, 32'd129140163, 32'd387420489, 32'd1162261467,
      32'd3486784401
   };

   localparam logic [CountWidth-1:0] POW3_TOP = 5'd20;

   localparam logic [1:0] REG_WINDOW_WIDTH = 2'd0;

   typedef struct packed {
      logic [ValueWidth-1:0] v;
      logic [CountWidth-1:0] a;
      logic [CountWidth-1:0] b;
      logic [CountWidth-1:0] pa;
      logic [CountWidth-1:0] pb;
      logic [ValueWidth-1:0] pv;
      logic                  nb;
      logic [CountWidth-1:0] w;
   } crp_state_type;

   function automatic logic [PowWidth-1:0] crp_pow3(input logic [CountWidth-1:0] a);
      logic [CountWidth-1:0] idx;
      idx = (a > POW3_TOP) ? POW3_TOP : a;
      return POW3[idx];
   endfunction

   // true when 3^a < 2^b
   function automatic logic crp_below(input logic [CountWidth-1:0] a,
                                      input logic [CountWidth-1:0] b);
      logic [PowWidth-1:0] p2;
      p2 = 32'd1 << b;
      return crp_pow3(a) < p2;
   endfunction

endpackage
`default_nettype wire

@@ rtl/crp_step.sv @@
// one collatz step stage of the walk pipeline
`default_nettype none
module crp_step (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire                   in_valid,
   input  crp_pkg::crp_state_type in_state,
   output logic                  out_valid,
   output crp_pkg::crp_state_type out_state
);
   import crp_pkg::*;

   logic          valid_ff;
   crp_state_type state_ff;
   crp_state_type state_in;
   logic [CmpWidth-1:0] lhs;
   logic [CmpWidth-1:0] rhs;

   always_comb begin
      state_in = in_state;
      lhs      = '0;
      rhs      = '0;
      if (in_state.b < in_state.w) begin
         if (crp_below(in_state.a, in_state.b)) begin
            state_in.nb = 1'b0;
         end
         if (in_state.v[0]) begin
            state_in.v = in_state.v + {in_state.v[ValueWidth-2:0], 1'b0} + 36'd1;
            if (in_state.a < POW3_TOP) begin
               state_in.a = in_state.a + 5'd1;
            end
            // ratio compare: 3^a * 2^pb > 3^pa * 2^b
            lhs = {20'd0, crp_pow3(state_in.a)} << in_state.pb;
            rhs = {20'd0, crp_pow3(in_state.pa)} << in_state.b;
            if (lhs > rhs) begin
               state_in.pa = state_in.a;
               state_in.pb = in_state.b;
               state_in.pv = state_in.v;
            end
         end else begin
            state_in.v = in_state.v >> 1;
            state_in.b = in_state.b + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule
`default_nettype wire

@@ rtl/collatz_residue_polynomial_core.sv @@
// top level: csr port, collatz step pipeline and result register
//
//   channel | ports                    | handshake
//   request | req_residue              | req_valid / req_ready
//   result  | rsp_* (eight fields)     | rsp_valid / rsp_ready
//   csr     | csr_p* window_width @ 0  | psel / penable, pready high
//
// one request enters per cycle while the result is not stalled; the path is
// 2*MAX_WIDTH step stages plus one result register.
// each stage performs one collatz step; stages past the window pass through.
// a stalled result freezes the whole pipeline; nothing is dropped or repeated.
// synchronous reset clears valid bits and sets window_width to 8.
`default_nettype none
module collatz_residue_polynomial_core #(
   parameter int MAX_WIDTH = 20
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [19:0] req_residue,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [4:0]  rsp_final_halvings,
   output logic [4:0]  rsp_final_triplings,
   output logic [35:0] rsp_final_value,
   output logic [4:0]  rsp_peak_halvings,
   output logic [4:0]  rsp_peak_triplings,
   output logic [35:0] rsp_peak_value,
   output logic        rsp_never_below_one,
   output logic        rsp_final_shrinks,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [1:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import crp_pkg::*;

   localparam int Stages = 2 * MAX_WIDTH;

   logic [4:0]    window_width_ff;
   logic [4:0]    width_sat;
   logic          advance;
   logic          stage_valid [Stages+1];
   crp_state_type stage_state [Stages+1];
   crp_state_type entry_state;
   crp_state_type last;
   logic          rsp_valid_ff;
   logic [4:0]    fh_ff, ft_ff, ph_ff, pt_ff;
   logic [35:0]   fv_ff, pv_ff;
   logic          nb_ff, sh_ff;
   logic          end_below;

   // csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_WINDOW_WIDTH) ? {27'd0, window_width_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff <= 5'd8;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == REG_WINDOW_WIDTH) begin
         window_width_ff <= csr_pwdata[4:0];
      end
   end

   assign width_sat = (window_width_ff > 5'(MAX_WIDTH)) ? 5'(MAX_WIDTH) : window_width_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      entry_state    = '0;
      entry_state.v  = {16'd0, req_residue};
      entry_state.nb = 1'b1;
      entry_state.w  = width_sat;
   end

   assign stage_state[0] = entry_state;
   assign stage_valid[0] = req_valid;

   for (genvar i = 0; i < Stages; i++) begin : g_step
      crp_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_state  (stage_state[i]),
         .out_valid (stage_valid[i+1]),
         .out_state (stage_state[i+1])
      );
   end

   assign last      = stage_state[Stages];
   assign end_below = crp_below(last.a, last.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[Stages];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fh_ff <= last.b;
         ft_ff <= last.a;
         fv_ff <= last.v;
         ph_ff <= last.pb;
         pt_ff <= last.pa;
         pv_ff <= last.pv;
         nb_ff <= last.nb && !end_below;
         sh_ff <= end_below;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_final_halvings  = fh_ff;
   assign rsp_final_triplings = ft_ff;
   assign rsp_final_value     = fv_ff;
   assign rsp_peak_halvings   = ph_ff;
   assign rsp_peak_triplings  = pt_ff;
   assign rsp_peak_value      = pv_ff;
   assign rsp_never_below_one = nb_ff;
   assign rsp_final_shrinks   = sh_ff;

`include "collatz_residue_polynomial_core_assert.svh"

   // every tripling is followed by a halving inside the window
   `CRP_ASSERT_IMP(a_trip_le_halv, rsp_valid, rsp_final_triplings <= rsp_final_halvings)
   `CRP_ASSERT_IMP(a_peak_le_final, rsp_valid, rsp_peak_triplings <= rsp_final_triplings)
   `CRP_ASSERT_IMP(a_no_peak_zero, rsp_valid && rsp_peak_triplings == 5'd0,
                   rsp_peak_value == 36'd0 && rsp_peak_halvings == 5'd0)
   `CRP_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid)

endmodule
`default_nettype wire
